### sv/batch_flush_controller_unit_macros.svh
// Assertion macros for the batch flush controller.
// Used by the top level; no other dependencies.
`ifndef BATCH_FLUSH_CONTROLLER_UNIT_MACROS_SVH
`define BATCH_FLUSH_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("batch flush controller check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("batch flush controller check failed");

`endif

### sv/bfc_pkg.sv
// Package for the batch flush controller: field widths, command and status
// codes, batch geometry constants. No dependencies.
`timescale 1ns / 1ps

package bfc_pkg;

    localparam int CMD_W     = 2;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int RECORDS_W = 16;
    localparam int BYTES_W   = 11;
    localparam int DROPS_W   = 32;
    localparam int CAP_W     = 16;
    localparam int AGE_W     = 32;
    localparam int BUDGET_W  = 42;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam int HEADER_LEN       = 24;
    localparam int RECORD_FIXED_LEN = 32;
    localparam int MAX_BATCH_LEN    = 1400;
    localparam int MAX_RECORD_DATA  = 1344;
    localparam int US_PER_MS        = 1000;

    localparam int DEFAULT_RECORD_CAP    = 32;
    localparam int DEFAULT_AGE_BUDGET_MS = 100;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_CHECK  = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_TOO_LARGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RECORD_CAP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_BUDGET_MS = 1'd1;

endpackage

### sv/bfc_req_if.sv
// Request channel of the batch flush controller: valid/ready plus one item.
// Depends on bfc_pkg.
`timescale 1ns / 1ps

interface bfc_req_if
    import bfc_pkg::*;
();
    logic                valid;
    logic                ready;
    t_cmd                cmd;
    logic [LEN_W-1:0]    record_len;
    logic [TIME_W-1:0]   record_time_us;
    logic [TIME_W-1:0]   now_us;

    modport source (output valid, cmd, record_len, record_time_us, now_us, input ready);
    modport sink   (input valid, cmd, record_len, record_time_us, now_us, output ready);
endinterface

### sv/bfc_rsp_if.sv
// Result channel of the batch flush controller: valid/ready plus one result.
// Depends on bfc_pkg.
`timescale 1ns / 1ps

interface bfc_rsp_if
    import bfc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic                 flush_due;
    logic [RECORDS_W-1:0] batch_records;
    logic [BYTES_W-1:0]   batch_bytes;
    logic [DROPS_W-1:0]   dropped_count;

    modport source (output valid, status, flush_due, batch_records, batch_bytes,
                    dropped_count, input ready);
    modport sink   (input valid, status, flush_due, batch_records, batch_bytes,
                    dropped_count, output ready);
endinterface

### sv/batch_flush_controller_unit.sv
// Batch flush controller top level: input register, admission/flush logic,
// result register. Depends on bfc_pkg, bfc_req_if, bfc_rsp_if and the macros.
`timescale 1ns / 1ps
`include "batch_flush_controller_unit_macros.svh"

// Usage
//   i_req  : request items (append, check flush due, clear batch), transfer on
//            valid && ready.
//   o_rsp  : one result per request, in order, transfer on valid && ready.
//   i_cfg_*: register writes (record cap, age budget), applied at the clock
//            edge; write only while no request is in flight.
// Order: a transferred request loads the input register; the result register
// and the batch state then load together from the input register.
// Throughput: one request per cycle while the receiver takes results; the
// state update, a 64-bit age subtract and compare, is the combinational
// path between the two registers.
// Reset (synchronous, active low) empties both registers, starts an empty
// batch, clears the drop counter and loads the default register values.
// When the receiver stalls, the result register holds and the input register
// takes one more request; ready then drops until the result moves.
module batch_flush_controller_unit
    import bfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfc_req_if.sink              i_req,
    bfc_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration
    logic [CAP_W-1:0]     r_cap;
    logic [BUDGET_W-1:0]  r_budget_us;
    logic [CAP_W-1:0]     w_cap_wr;
    logic [AGE_W-1:0]     w_age_wr;

    // input register
    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic [LEN_W-1:0]     r_in_len;
    logic [TIME_W-1:0]    r_in_time;
    logic [TIME_W-1:0]    r_in_now;

    // batch state
    logic [BYTES_W-1:0]   r_bytes,   n_bytes;
    logic [RECORDS_W-1:0] r_records, n_records;
    logic [TIME_W-1:0]    r_first,   n_first;
    logic [DROPS_W-1:0]   r_drops,   n_drops;

    // result register
    logic                 r_out_valid;
    t_status              r_out_status, n_status;
    logic                 r_out_due,    n_due;

    logic                 w_adv_out;
    logic                 w_adv_in;
    logic                 w_too_large;
    logic                 w_full;
    logic [LEN_W:0]       w_need;
    logic                 w_size_due;
    logic [TIME_W:0]      w_age;

    assign w_adv_out   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_adv_in    = !r_in_valid || w_adv_out;
    assign i_req.ready = w_adv_in;

    assign w_cap_wr = i_cfg_data[CAP_W-1:0];
    assign w_age_wr = i_cfg_data[AGE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(DEFAULT_RECORD_CAP);
            r_budget_us <= BUDGET_W'(DEFAULT_AGE_BUDGET_MS * US_PER_MS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RECORD_CAP: begin
                    r_cap <= (w_cap_wr == '0) ? CAP_W'(DEFAULT_RECORD_CAP) : w_cap_wr;
                end
                REG_AGE_BUDGET_MS: begin
                    // keep the budget in microseconds so the item path only compares
                    r_budget_us <= (w_age_wr == '0)
                        ? BUDGET_W'(DEFAULT_AGE_BUDGET_MS * US_PER_MS)
                        : BUDGET_W'(w_age_wr) * BUDGET_W'(US_PER_MS);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv_in) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in) begin
            r_in_cmd  <= i_req.cmd;
            r_in_len  <= i_req.record_len;
            r_in_time <= i_req.record_time_us;
            r_in_now  <= i_req.now_us;
        end
    end

    assign w_too_large = r_in_len > LEN_W'(MAX_RECORD_DATA);
    assign w_need      = (LEN_W+1)'(r_bytes) + (LEN_W+1)'(RECORD_FIXED_LEN)
                       + (LEN_W+1)'(r_in_len);
    assign w_full      = (r_records >= r_cap) || (w_need > (LEN_W+1)'(MAX_BATCH_LEN));
    assign w_size_due  = (BYTES_W+1)'(r_bytes) + (BYTES_W+1)'(RECORD_FIXED_LEN)
                       > (BYTES_W+1)'(MAX_BATCH_LEN);
    // top bit set means the clock is behind the batch stamp
    assign w_age       = {1'b0, r_in_now} - {1'b0, r_first};

    always_comb begin
        n_bytes   = r_bytes;
        n_records = r_records;
        n_first   = r_first;
        n_drops   = r_drops;
        n_status  = ST_OK;
        n_due     = 1'b0;
        unique case (r_in_cmd)
            CMD_APPEND: begin
                if (w_too_large) begin
                    n_drops  = r_drops + DROPS_W'(1);
                    n_status = ST_TOO_LARGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    if (r_records == '0) begin
                        n_first = r_in_time;
                    end
                    n_bytes   = w_need[BYTES_W-1:0];
                    n_records = r_records + RECORDS_W'(1);
                end
            end
            CMD_CHECK: begin
                if (r_records != '0) begin
                    n_due = (r_records >= r_cap) || w_size_due
                         || (!w_age[TIME_W] && (w_age[TIME_W-1:0] >= TIME_W'(r_budget_us)));
                end
            end
            CMD_CLEAR: begin
                n_bytes   = BYTES_W'(HEADER_LEN);
                n_records = '0;
                n_first   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes     <= BYTES_W'(HEADER_LEN);
            r_records   <= '0;
            r_first     <= '0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_out) begin
                r_bytes   <= n_bytes;
                r_records <= n_records;
                r_first   <= n_first;
                r_drops   <= n_drops;
            end
            // hold the result while the receiver stalls
            if (!r_out_valid || o_rsp.ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_status <= n_status;
            r_out_due    <= n_due;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.flush_due     = r_out_due;
    assign o_rsp.batch_records = r_records;
    assign o_rsp.batch_bytes   = r_bytes;
    assign o_rsp.dropped_count = r_drops;

    `BFC_ASSERT_IMPL(a_empty_batch, i_clk, i_rst_n, r_records == '0,
        r_bytes == BYTES_W'(HEADER_LEN) && r_first == '0)
    `BFC_ASSERT_NEXT(a_drop_count, i_clk, i_rst_n,
        w_adv_out && r_in_cmd == CMD_APPEND && w_too_large,
        r_drops == $past(r_drops) + DROPS_W'(1))
    `BFC_ASSERT_IMPL(a_due_needs_records, i_clk, i_rst_n, r_out_valid && r_out_due,
        r_out_status == ST_OK && r_records != '0)

endmodule

### sim/batch_outcome_checker.sv
// Watches the request, result and register-write ports of the batch flush controller,
// predicts each result and compares it field by field. Depends on bfc_pkg,
// bfc_req_if and bfc_rsp_if.
`timescale 1ns / 1ps

module batch_outcome_checker
    import bfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfc_req_if                   req,
    bfc_rsp_if                   rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status              status;
        logic                 flush_due;
        logic [RECORDS_W-1:0] batch_records;
        logic [BYTES_W-1:0]   batch_bytes;
        logic [DROPS_W-1:0]   dropped_count;
    } t_batch_outcome;

    // Mirror of the batch state and the registers
    int                 used_bytes   = HEADER_LEN;
    int                 held_records = 0;
    logic [TIME_W-1:0]  batch_stamp  = '0;
    logic [DROPS_W-1:0] drop_total   = '0;
    int                 cap_limit    = DEFAULT_RECORD_CAP;
    logic [AGE_W-1:0]   age_budget   = AGE_W'(DEFAULT_AGE_BUDGET_MS);

    t_batch_outcome outcome_q[$];
    int             fail_total    = 0;
    int             pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic start_batch();
        used_bytes   = HEADER_LEN;
        held_records = 0;
        batch_stamp  = '0;
    endtask

    task automatic apply_batch_item(input t_cmd cmd, input logic [LEN_W-1:0] len,
                                    input logic [TIME_W-1:0] stamp,
                                    input logic [TIME_W-1:0] now,
                                    output t_batch_outcome res);
        logic [TIME_W-1:0] budget_us;
        budget_us = TIME_W'(age_budget) * TIME_W'(US_PER_MS);
        res = '0;
        case (cmd)
            CMD_APPEND: begin
                if (int'(len) > MAX_RECORD_DATA) begin
                    drop_total = drop_total + 1'b1;
                    res.status = ST_TOO_LARGE;
                end else if (held_records >= cap_limit) begin
                    res.status = ST_FULL;
                end else if (used_bytes + RECORD_FIXED_LEN + int'(len) > MAX_BATCH_LEN) begin
                    res.status = ST_FULL;
                end else begin
                    if (held_records == 0)
                        batch_stamp = stamp;
                    used_bytes   = used_bytes + RECORD_FIXED_LEN + int'(len);
                    held_records = held_records + 1;
                end
            end
            CMD_CHECK: begin
                if (held_records == 0)
                    res.flush_due = 1'b0;
                else if (held_records >= cap_limit)
                    res.flush_due = 1'b1;
                else if (used_bytes + RECORD_FIXED_LEN > MAX_BATCH_LEN)
                    res.flush_due = 1'b1;
                // skip the age trigger while the clock is behind the stamp
                else if (now >= batch_stamp && (now - batch_stamp) >= budget_us)
                    res.flush_due = 1'b1;
            end
            CMD_CLEAR: start_batch();
            default: ;
        endcase
        res.batch_records = RECORDS_W'(held_records);
        res.batch_bytes   = BYTES_W'(used_bytes);
        res.dropped_count = drop_total;
    endtask

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_batch_outcome want;
        t_batch_outcome got;
        if (!i_rst_n) begin
            cap_limit  = DEFAULT_RECORD_CAP;
            age_budget = AGE_W'(DEFAULT_AGE_BUDGET_MS);
            drop_total = '0;
            start_batch();
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_RECORD_CAP)
                    cap_limit = (i_cfg_data[CAP_W-1:0] == '0) ? DEFAULT_RECORD_CAP
                                                              : int'(i_cfg_data[CAP_W-1:0]);
                else if (i_cfg_idx == REG_AGE_BUDGET_MS)
                    age_budget = (i_cfg_data[AGE_W-1:0] == '0) ? AGE_W'(DEFAULT_AGE_BUDGET_MS)
                                                               : i_cfg_data[AGE_W-1:0];
            end
            // results are registered behind their requests: retire before predicting
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.flush_due, rsp.batch_records, rsp.batch_bytes,
                        rsp.dropped_count};
                if (outcome_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_total++;
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("flush_due", want.flush_due, got.flush_due);
                    compare_field("batch_records", want.batch_records, got.batch_records);
                    compare_field("batch_bytes", want.batch_bytes, got.batch_bytes);
                    compare_field("dropped_count", want.dropped_count, got.dropped_count);
                end
            end
            if (req.valid && req.ready) begin
                apply_batch_item(req.cmd, req.record_len, req.record_time_us, req.now_us,
                                 want);
                outcome_q.push_back(want);
            end
        end
        pending_total = outcome_q.size();
    end

endmodule

### sim/tb_batch_flush_controller_unit.sv
// Top of the batch flush controller testbench: clock, reset, request and
// register-write stimulus, result back-pressure and the verdict.
// Depends on bfc_pkg, the channel interfaces, batch_outcome_checker and the block.
`timescale 1ns / 1ps

module tb_batch_flush_controller_unit;
    import bfc_pkg::*;

    localparam t_cmd              CMD_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam int                PHASES     = 10;
    localparam int                PHASE_LEN  = 153;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;

    bit                no_gaps         = 1'b0;
    int                rsp_hold_cycles = 0;
    logic [AGE_W-1:0]  budget_now      = AGE_W'(DEFAULT_AGE_BUDGET_MS);
    logic [TIME_W-1:0] base_time       = '0;

    bfc_req_if req_if();
    bfc_rsp_if rsp_if();

    batch_flush_controller_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    batch_outcome_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // Returns right after the accepting edge; valid stays up until the next call.
    task automatic send_item(input t_cmd cmd, input logic [LEN_W-1:0] len,
                             input logic [TIME_W-1:0] stamp,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.cmd            <= cmd;
        req_if.record_len     <= len;
        req_if.record_time_us <= stamp;
        req_if.now_us         <= now;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid and hold until every outstanding result has transferred.
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_AGE_BUDGET_MS)
            budget_now = (data == '0) ? AGE_W'(DEFAULT_AGE_BUDGET_MS) : data;
    endtask

    task automatic random_item();
        int                pick;
        int                delta;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] budget_us;
        pick      = $urandom_range(0, 99);
        delta     = int'($urandom_range(0, 8)) - 4;
        budget_us = TIME_W'(budget_now) * TIME_W'(US_PER_MS);
        stamp     = base_time + TIME_W'($urandom_range(0, 3));
        now       = rand_time();
        if (pick < 55) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: len = LEN_W'($urandom_range(0, 40));
                9, 10, 11, 12, 13:         len = LEN_W'($urandom_range(100, 700));
                14, 15:                    len = LEN_W'($urandom_range(1330, 1360));
                default:                   len = LEN_W'($urandom);
            endcase
            send_item(CMD_APPEND, len, stamp, now);
        end else if (pick < 90) begin
            // aim half of the checks at the edge of the age budget
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: now = base_time + budget_us + TIME_W'(delta);
                10, 11, 12:                   now = base_time + TIME_W'(delta);
                13, 14, 15:                   now = base_time + TIME_W'($urandom) % (budget_us + 1);
                default:                      ;
            endcase
            send_item(CMD_CHECK, LEN_W'($urandom), rand_time(), now);
        end else if (pick < 96) begin
            case ($urandom_range(0, 6))
                0:       base_time = TIME_MAX - TIME_W'($urandom_range(0, 10));
                1:       base_time = TIME_W'($urandom_range(0, 1000));
                default: base_time = rand_time();
            endcase
            send_item(CMD_CLEAR, LEN_W'($urandom), rand_time(), rand_time());
        end else begin
            send_item(CMD_UNUSED, LEN_W'($urandom), rand_time(), rand_time());
        end
    endtask

    // Result side: a drawn stall before each transfer, plus any long hold requested.
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        forever begin
            stall           = rsp_hold_cycles + draw_gap();
            rsp_hold_cycles = 0;
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin
        req_if.valid          = 1'b0;
        req_if.cmd            = CMD_APPEND;
        req_if.record_len     = '0;
        req_if.record_time_us = '0;
        req_if.now_us         = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty batch, unused command, size limits, clock behind stamp,
        // age boundary, full by bytes and by count, register extremes.
        send_item(CMD_CHECK, '1, TIME_MAX, TIME_MAX);
        send_item(CMD_UNUSED, '1, TIME_MAX, TIME_MAX);
        send_item(CMD_APPEND, LEN_W'(MAX_RECORD_DATA + 1), '0, '0);
        send_item(CMD_APPEND, '1, '0, '0);
        send_item(CMD_APPEND, '0, 64'd1000, '0);
        send_item(CMD_APPEND, LEN_W'(MAX_RECORD_DATA), 64'd1, '0);
        send_item(CMD_CHECK, '0, '0, 64'd999);
        send_item(CMD_CHECK, '0, '0, 64'd100_999);
        send_item(CMD_CHECK, '0, '0, 64'd101_000);
        send_item(CMD_CLEAR, '1, TIME_MAX, TIME_MAX);
        send_item(CMD_APPEND, LEN_W'(MAX_RECORD_DATA), TIME_MAX, '0);
        send_item(CMD_CHECK, '0, '0, '0);
        send_item(CMD_APPEND, '0, '0, '0);
        send_item(CMD_CLEAR, '0, '0, '0);
        send_item(CMD_APPEND, LEN_W'(5), TIME_MAX, '0);
        send_item(CMD_CHECK, '0, '0, TIME_MAX);
        send_item(CMD_CHECK, '0, '0, '0);
        write_reg(REG_RECORD_CAP, 32'hABCD_0001);
        send_item(CMD_APPEND, '0, '0, '0);
        send_item(CMD_CHECK, '0, '0, TIME_MAX);
        send_item(CMD_CLEAR, '0, '0, '0);
        send_item(CMD_APPEND, '0, 64'd7, '0);
        send_item(CMD_APPEND, '0, 64'd8, '0);
        write_reg(REG_RECORD_CAP, 32'hFFFF_0000);
        send_item(CMD_APPEND, '0, 64'd9, '0);
        send_item(CMD_CHECK, '0, '0, 64'd1006);
        write_reg(REG_AGE_BUDGET_MS, 32'd1);
        send_item(CMD_CHECK, '0, '0, 64'd1006);
        send_item(CMD_CHECK, '0, '0, 64'd1007);
        write_reg(REG_AGE_BUDGET_MS, 32'hFFFF_FFFF);
        send_item(CMD_CHECK, '0, '0, TIME_MAX);
        write_reg(REG_AGE_BUDGET_MS, 32'd0);
        send_item(CMD_CHECK, '0, '0, 64'd1007);
        write_reg(REG_RECORD_CAP, 32'h0000_FFFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       write_reg(REG_RECORD_CAP, {16'($urandom), 16'd1});
                1:       write_reg(REG_RECORD_CAP, {16'($urandom), 16'd0});
                2:       write_reg(REG_RECORD_CAP, {16'($urandom), 16'hFFFF});
                3:       write_reg(REG_RECORD_CAP, {16'($urandom), 16'($urandom_range(1, 10))});
                4:       write_reg(REG_RECORD_CAP, {16'($urandom), 16'($urandom_range(40, 45))});
                default: write_reg(REG_RECORD_CAP, $urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_AGE_BUDGET_MS, 32'd1);
                1:       write_reg(REG_AGE_BUDGET_MS, 32'd0);
                2:       write_reg(REG_AGE_BUDGET_MS, 32'hFFFF_FFFF);
                3, 4:    write_reg(REG_AGE_BUDGET_MS, 32'($urandom_range(1, 200)));
                default: write_reg(REG_AGE_BUDGET_MS, $urandom);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            // stall the result side for a long stretch while requests keep coming
            if (phase == 2) begin
                no_gaps         = 1'b1;
                rsp_hold_cycles = 400;
            end
            send_item(CMD_CLEAR, LEN_W'($urandom), rand_time(), rand_time());
            for (int k = 0; k < PHASE_LEN; k++)
                random_item();
        end

        drain_results();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
